/* rtl/tblm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tblm_pkg: shared types and constants for the triple buffer lease manager
// Holds the command and status codes and the field and beat widths.
// ----------------------------------------------------------------------------
package tblm_pkg;

  localparam int CMD_W    = 3;
  localparam int IDX_W    = 3;
  localparam int GEN_W    = 32;
  localparam int STATUS_W = 2;

  // command (3) + lease_index (3) + lease_generation (32), padded to 40
  localparam int IN_FIELDS_W = CMD_W + IDX_W + GEN_W;
  localparam int IN_TDATA_W  = 40;
  // status (2) + buffer_number (3) + current_generation (32) + front_number (3)
  localparam int OUT_TDATA_W = STATUS_W + IDX_W + GEN_W + IDX_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACQUIRE     = 3'd0,
    CMD_RELEASE     = 3'd1,
    CMD_BEGIN_FRAME = 3'd2,
    CMD_PUBLISH     = 3'd3,
    CMD_REALLOCATE  = 3'd4,
    CMD_SHUTDOWN    = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_NONE    = 2'd1,
    STATUS_IGNORED = 2'd2
  } status_t;

endpackage

/* rtl/triple_buffer_lease_manager.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triple_buffer_lease_manager: lease bookkeeping for a ring of frame buffers
// Readers lease and release the front buffer; the writer claims a back
// buffer, publishes it, and reallocates or shuts down the ring.
// ----------------------------------------------------------------------------
// Each command beat yields exactly one result beat. A command is captured in
// an input register, evaluated against the buffer state in one pass of logic,
// and the result is registered in an output register, which holds it until taken.
// One command per cycle is taken as long as the result register drains; the
// rate is set by that single state-update pass, which completes every cycle.
// current_generation and front_number report the state after the command.
module triple_buffer_lease_manager #(
  parameter int RING_SIZE        = 3,
  parameter int LEASE_COUNT_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [2:0] command, [5:3] lease_index, [37:6] lease_generation, [39:38] zero
  input  logic [tblm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [1:0] status, [4:2] buffer_number, [36:5] current_generation,
  // [39:37] front_number
  output logic [tblm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int IDX_W  = tblm_pkg::IDX_W;
  localparam int GEN_W  = tblm_pkg::GEN_W;
  localparam int CAND_W = IDX_W + 1;

  // input register
  logic                       in_valid;
  logic [tblm_pkg::CMD_W-1:0] in_cmd;
  logic [IDX_W-1:0]           in_idx;
  logic [GEN_W-1:0]           in_gen;

  // buffer state
  logic [IDX_W-1:0]            front, front_next;
  logic [IDX_W-1:0]            back, back_next;
  logic                        back_valid, back_valid_next;
  logic [LEASE_COUNT_BITS-1:0] counts      [RING_SIZE];
  logic [LEASE_COUNT_BITS-1:0] counts_next [RING_SIZE];
  logic [GEN_W-1:0]            gen, gen_next;
  logic                        present, present_next;

  // result register
  logic                      out_valid;
  tblm_pkg::status_t         out_status, status_next;
  logic [IDX_W-1:0]          out_bufnum, bufnum_next;
  logic [GEN_W-1:0]          out_gen;
  logic [IDX_W-1:0]          out_front;

  logic                      advance;
  logic [RING_SIZE-1:0]      zero, full, rel_hit;
  logic                      rel_ok;
  logic                      pick_found;
  logic [IDX_W-1:0]          pick;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd <= s_axis_tdata[tblm_pkg::CMD_W-1:0];
      in_idx <= s_axis_tdata[tblm_pkg::CMD_W +: IDX_W];
      in_gen <= s_axis_tdata[tblm_pkg::CMD_W + IDX_W +: GEN_W];
    end
  end

  // per-entry flags
  always_comb begin
    for (int i = 0; i < RING_SIZE; i++) begin
      zero[i]    = (counts[i] == '0);
      full[i]    = (counts[i] == '1);
      rel_hit[i] = (in_idx == IDX_W'(i)) && !zero[i];
    end
  end

  assign rel_ok = (in_gen == gen) && (|rel_hit);

  // first free buffer after the front, in ring order; scan from the far end
  // so the nearest candidate wins
  always_comb begin
    logic [CAND_W-1:0] cand;
    pick_found = 1'b0;
    pick       = '0;
    for (int off = RING_SIZE - 1; off >= 1; off--) begin
      cand = {1'b0, front} + CAND_W'(off);
      if (cand >= CAND_W'(RING_SIZE)) begin
        cand = cand - CAND_W'(RING_SIZE);
      end
      for (int i = 0; i < RING_SIZE; i++) begin
        if (cand == CAND_W'(i) && zero[i]) begin
          pick_found = 1'b1;
          pick       = IDX_W'(i);
        end
      end
    end
  end

  always_comb begin
    front_next      = front;
    back_next       = back;
    back_valid_next = back_valid;
    gen_next        = gen;
    present_next    = present;
    status_next     = tblm_pkg::STATUS_DONE;
    bufnum_next     = '0;
    for (int i = 0; i < RING_SIZE; i++) begin
      counts_next[i] = counts[i];
    end
    case (tblm_pkg::cmd_t'(in_cmd))
      tblm_pkg::CMD_ACQUIRE: begin
        if (!present) begin
          status_next = tblm_pkg::STATUS_NONE;
        end else begin
          bufnum_next = front;
          for (int i = 0; i < RING_SIZE; i++) begin
            if (front == IDX_W'(i) && !full[i]) begin
              counts_next[i] = counts[i] + 1'b1;
            end
          end
        end
      end
      tblm_pkg::CMD_RELEASE: begin
        bufnum_next = in_idx;
        if (rel_ok) begin
          for (int i = 0; i < RING_SIZE; i++) begin
            if (rel_hit[i]) begin
              counts_next[i] = counts[i] - 1'b1;
            end
          end
        end else begin
          status_next = tblm_pkg::STATUS_IGNORED;
        end
      end
      tblm_pkg::CMD_BEGIN_FRAME: begin
        if (present && pick_found) begin
          back_next       = pick;
          back_valid_next = 1'b1;
          bufnum_next     = pick;
        end else begin
          back_valid_next = 1'b0;
          status_next     = tblm_pkg::STATUS_NONE;
        end
      end
      tblm_pkg::CMD_PUBLISH: begin
        if (back_valid) begin
          front_next  = back;
          bufnum_next = back;
        end else begin
          status_next = tblm_pkg::STATUS_NONE;
        end
      end
      tblm_pkg::CMD_REALLOCATE: begin
        for (int i = 0; i < RING_SIZE; i++) begin
          counts_next[i] = '0;
        end
        front_next      = '0;
        gen_next        = gen + 1'b1;
        present_next    = 1'b1;
        // all counts cleared and front at 0: the next buffer in the ring is free
        back_next       = IDX_W'(1);
        back_valid_next = 1'b1;
        bufnum_next     = IDX_W'(1);
      end
      tblm_pkg::CMD_SHUTDOWN: begin
        for (int i = 0; i < RING_SIZE; i++) begin
          counts_next[i] = '0;
        end
        front_next      = '0;
        gen_next        = gen + 1'b1;
        back_valid_next = 1'b0;
        present_next    = 1'b0;
      end
      default: begin
        status_next = tblm_pkg::STATUS_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front      <= '0;
      back       <= '0;
      back_valid <= 1'b0;
      gen        <= '0;
      present    <= 1'b0;
      for (int i = 0; i < RING_SIZE; i++) begin
        counts[i] <= '0;
      end
    end else if (advance) begin
      front      <= front_next;
      back       <= back_next;
      back_valid <= back_valid_next;
      gen        <= gen_next;
      present    <= present_next;
      for (int i = 0; i < RING_SIZE; i++) begin
        counts[i] <= counts_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status <= status_next;
      out_bufnum <= bufnum_next;
      out_gen    <= gen_next;
      out_front  <= front_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_front, out_gen, out_bufnum, out_status};

endmodule

/* rtl/tblm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tblm_checker: port-level checks for the triple buffer lease manager
// Watches the result stream for reset behavior, beat stability and codes.
// ----------------------------------------------------------------------------
module tblm_checker #(
  parameter int RING_SIZE = 3
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [tblm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // no result beat right after reset
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat valid after reset");

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  // front buffer always inside the ring
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (32'(m_axis_tdata[39:37]) < RING_SIZE))
    else $error("front_number out of range");

  // a command with status NONE reports buffer 0
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[1:0] == tblm_pkg::STATUS_NONE)
      |-> (m_axis_tdata[4:2] == 3'd0))
    else $error("buffer_number set on unavailable status");

endmodule

bind triple_buffer_lease_manager tblm_checker #(
  .RING_SIZE(RING_SIZE)
) u_tblm_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for triple_buffer_lease_manager
// Drives command beats with random gaps, predicts every result beat in a
// scoreboard that tracks front/back buffers, lease counts and generation, and
// compares each result beat field by field. A directed opener walks the
// corner cases; a random phase then mixes begin-frame and publish commands, valid and
// stale releases, reallocation, shutdown and junk commands.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CMD_W       = tblm_pkg::CMD_W;
  localparam int IDX_W       = tblm_pkg::IDX_W;
  localparam int GEN_W       = tblm_pkg::GEN_W;
  localparam int STATUS_W    = tblm_pkg::STATUS_W;
  localparam int IN_FIELDS_W = tblm_pkg::IN_FIELDS_W;
  localparam int IN_TDATA_W  = tblm_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = tblm_pkg::OUT_TDATA_W;

  localparam int NBUF       = 3;
  localparam int CNT_W      = 8;
  localparam int N_RANDOM   = 1600;
  localparam int LONG_HOLD  = 400;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_WAIT = 8;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef struct {
    tblm_pkg::status_t status;
    logic [IDX_W-1:0]  buf_num;
    logic [GEN_W-1:0]  gen;
    logic [IDX_W-1:0]  front;
  } lease_result_t;

  // Tracks buffer ring state and queues the result each command should give.
  class lease_scoreboard;
    logic [IDX_W-1:0] front_buf;
    logic [IDX_W-1:0] back_buf;
    bit               back_ok;
    logic [CNT_W-1:0] counts [NBUF];
    logic [GEN_W-1:0] gen_stamp;
    bit               present;
    lease_result_t    pending [$];
    int               errors;

    function new();
      front_buf = '0;
      back_buf  = '0;
      back_ok   = 1'b0;
      foreach (counts[i]) counts[i] = '0;
      gen_stamp = '0;
      present   = 1'b0;
      errors    = 0;
    endfunction

    // first lease-free buffer after the front, walking the ring
    function bit find_back(output logic [IDX_W-1:0] pick);
      int cand;
      pick = '0;
      for (int off = 1; off < NBUF; off++) begin
        cand = (int'(front_buf) + off) % NBUF;
        if (cand != int'(front_buf) && counts[cand] == '0) begin
          pick = cand[IDX_W-1:0];
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void clear_ring();
      foreach (counts[i]) counts[i] = '0;
      front_buf = '0;
      gen_stamp = gen_stamp + 1'b1;
    endfunction

    function void note_command(input logic [IN_TDATA_W-1:0] beat);
      logic [CMD_W-1:0] code;
      logic [IDX_W-1:0] idx;
      logic [GEN_W-1:0] lgen;
      logic [IDX_W-1:0] pick;
      lease_result_t    r;
      code = beat[CMD_W-1:0];
      idx  = beat[CMD_W +: IDX_W];
      lgen = beat[CMD_W+IDX_W +: GEN_W];
      r.status  = tblm_pkg::STATUS_DONE;
      r.buf_num = '0;
      case (code)
        tblm_pkg::CMD_ACQUIRE: begin
          if (!present) begin
            r.status = tblm_pkg::STATUS_NONE;
          end else begin
            if (counts[front_buf] != COUNT_MAX) counts[front_buf]++;
            r.buf_num = front_buf;
          end
        end
        tblm_pkg::CMD_RELEASE: begin
          r.buf_num = idx;
          if (int'(idx) >= NBUF || lgen != gen_stamp || counts[idx] == '0) begin
            r.status = tblm_pkg::STATUS_IGNORED;
          end else begin
            counts[idx]--;
          end
        end
        tblm_pkg::CMD_BEGIN_FRAME: begin
          if (present && find_back(pick)) begin
            back_buf  = pick;
            back_ok   = 1'b1;
            r.buf_num = pick;
          end else begin
            back_ok  = 1'b0;
            r.status = tblm_pkg::STATUS_NONE;
          end
        end
        tblm_pkg::CMD_PUBLISH: begin
          if (back_ok) begin
            front_buf = back_buf;
            r.buf_num = back_buf;
          end else begin
            r.status = tblm_pkg::STATUS_NONE;
          end
        end
        tblm_pkg::CMD_REALLOCATE: begin
          clear_ring();
          present = 1'b1;
          if (find_back(pick)) begin
            back_buf  = pick;
            back_ok   = 1'b1;
            r.buf_num = pick;
          end else begin
            back_ok = 1'b0;
          end
        end
        tblm_pkg::CMD_SHUTDOWN: begin
          clear_ring();
          back_ok = 1'b0;
          present = 1'b0;
        end
        default: r.status = tblm_pkg::STATUS_IGNORED;
      endcase
      r.gen   = gen_stamp;
      r.front = front_buf;
      pending.push_back(r);
    endfunction

    function void check_result(input logic [OUT_TDATA_W-1:0] beat);
      lease_result_t       want;
      logic [STATUS_W-1:0] got_status;
      logic [IDX_W-1:0]    got_buf;
      logic [GEN_W-1:0]    got_gen;
      logic [IDX_W-1:0]    got_front;
      got_status = beat[STATUS_W-1:0];
      got_buf    = beat[STATUS_W +: IDX_W];
      got_gen    = beat[STATUS_W+IDX_W +: GEN_W];
      got_front  = beat[STATUS_W+IDX_W+GEN_W +: IDX_W];
      if (pending.size() == 0) begin
        $error("unexpected result beat %h", beat);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got_status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got_status);
        errors++;
      end
      if (got_buf !== want.buf_num) begin
        $error("buffer_number: expected %0d, got %0d", want.buf_num, got_buf);
        errors++;
      end
      if (got_gen !== want.gen) begin
        $error("current_generation: expected %h, got %h", want.gen, got_gen);
        errors++;
      end
      if (got_front !== want.front) begin
        $error("front_number: expected %0d, got %0d", want.front, got_front);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  lease_scoreboard sb;
  bit no_idle;
  bit long_hold_req;
  int idle_cycles = 0;

  triple_buffer_lease_manager #(
    .RING_SIZE       (NBUF),
    .LEASE_COUNT_BITS(CNT_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // every accepted beat on either side goes through the scoreboard
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_command(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int gap;
    m_axis_tready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
      end
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  task automatic issue(input logic [CMD_W-1:0] code, input logic [IDX_W-1:0] idx,
                       input logic [GEN_W-1:0] lgen);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W-IN_FIELDS_W){1'b0}}, lgen, idx, code};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic issue_plain(input tblm_pkg::cmd_t code);
    issue(code, IDX_W'($urandom_range(0, 7)), GEN_W'($urandom()));
  endtask

  // mostly release a lease that is really held, if there is one; else a random one
  task automatic issue_release();
    int held [$];
    int pick;
    foreach (sb.counts[i]) if (sb.counts[i] != '0) held.push_back(i);
    if (held.size() > 0 && $urandom_range(0, 99) < 80) begin
      pick = held[$urandom_range(0, held.size() - 1)];
      issue(tblm_pkg::CMD_RELEASE, IDX_W'(pick), sb.gen_stamp);
    end else if ($urandom_range(0, 1) == 0) begin
      issue(tblm_pkg::CMD_RELEASE, IDX_W'($urandom_range(0, 7)), sb.gen_stamp);
    end else begin
      issue(tblm_pkg::CMD_RELEASE, IDX_W'($urandom_range(0, 7)), GEN_W'($urandom()));
    end
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25)      issue_plain(tblm_pkg::CMD_ACQUIRE);
    else if (r < 50) issue_release();
    else if (r < 68) issue_plain(tblm_pkg::CMD_BEGIN_FRAME);
    else if (r < 85) issue_plain(tblm_pkg::CMD_PUBLISH);
    else if (r < 91) issue_plain(tblm_pkg::CMD_REALLOCATE);
    else if (r < 94) issue_plain(tblm_pkg::CMD_SHUTDOWN);
    else if (r < 97) issue(CMD_W'($urandom_range(6, 7)), IDX_W'($urandom_range(0, 7)),
                           GEN_W'($urandom()));
    else             issue(CMD_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                           GEN_W'($urandom()));
  endtask

  // fill one lease count to saturation, with a long hold on the result side
  task automatic saturate_front();
    no_idle = 1'b1;
    issue_plain(tblm_pkg::CMD_REALLOCATE);
    long_hold_req = 1'b1;
    repeat (int'(COUNT_MAX) + 5) issue_plain(tblm_pkg::CMD_ACQUIRE);
    issue_plain(tblm_pkg::CMD_BEGIN_FRAME);
    issue_plain(tblm_pkg::CMD_PUBLISH);
    repeat (3) issue(tblm_pkg::CMD_RELEASE, '0, sb.gen_stamp);
    no_idle = 1'b0;
  endtask

  initial begin : stimulus
    sb            = new();
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    no_idle       = 1'b0;
    long_hold_req = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // no buffers yet: everything fails or is ignored
    issue(tblm_pkg::CMD_ACQUIRE, '0, '0);
    issue(tblm_pkg::CMD_BEGIN_FRAME, '0, '0);
    issue(tblm_pkg::CMD_PUBLISH, '0, '0);
    issue(tblm_pkg::CMD_RELEASE, '0, '0);
    issue(CMD_W'(6), '0, '0);
    issue(CMD_W'(7), 3'd7, '1);
    issue(tblm_pkg::CMD_REALLOCATE, 3'd7, '1);
    issue(tblm_pkg::CMD_ACQUIRE, '0, '0);
    issue(tblm_pkg::CMD_RELEASE, '0, '0);          // stale generation
    issue(tblm_pkg::CMD_RELEASE, 3'd5, 32'd1);     // index past the ring
    issue(tblm_pkg::CMD_RELEASE, '0, 32'd1);
    issue(tblm_pkg::CMD_RELEASE, '0, 32'd1);       // count already zero
    issue(tblm_pkg::CMD_BEGIN_FRAME, '0, '0);
    issue(tblm_pkg::CMD_PUBLISH, '0, '0);
    issue(tblm_pkg::CMD_ACQUIRE, '0, '0);
    issue(tblm_pkg::CMD_BEGIN_FRAME, '0, '0);
    issue(tblm_pkg::CMD_ACQUIRE, '0, '0);
    issue(tblm_pkg::CMD_PUBLISH, '0, '0);
    issue(tblm_pkg::CMD_ACQUIRE, '0, '0);
    issue(tblm_pkg::CMD_BEGIN_FRAME, '0, '0);
    issue(tblm_pkg::CMD_PUBLISH, '0, '0);
    issue(tblm_pkg::CMD_ACQUIRE, '0, '0);
    issue(tblm_pkg::CMD_BEGIN_FRAME, '0, '0);      // every buffer leased
    issue(tblm_pkg::CMD_PUBLISH, '0, '0);          // back buffer gone
    issue(tblm_pkg::CMD_SHUTDOWN, '0, '0);
    issue(tblm_pkg::CMD_RELEASE, '0, 32'd2);       // leases dropped by shutdown

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 600) saturate_front();
      if (n % 300 == 150) no_idle = 1'b1;
      if (n % 300 == 200) no_idle = 1'b0;
      random_item();
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
